// ===== hw/rtl/acs_pkg.sv =====
package acs_pkg;

  // Sizes of the channel list and its fields
  localparam int unsigned MAX_ENTRIES = 32;
  localparam int unsigned IDX_W       = $clog2(MAX_ENTRIES);
  localparam int unsigned CHAN_W      = 5;
  localparam int unsigned SAMPLE_W    = 8;
  localparam int unsigned LEN_W       = 6;
  localparam int unsigned POS_W       = 6;
  localparam int unsigned REQ_W       = 3;
  localparam int unsigned STATUS_W    = 2;

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_INIT  = 3'd0,
    REQ_WRITE = 3'd1,
    REQ_START = 3'd2,
    REQ_CONV  = 3'd3,
    REQ_READ  = 3'd4
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_REJECT   = 2'd1,
    ST_MISMATCH = 2'd2,
    ST_FAULT    = 2'd3
  } status_e;

  typedef struct packed {
    logic [REQ_W-1:0]    req_type;
    logic [IDX_W-1:0]    entry_index;
    logic [CHAN_W-1:0]   entry_channel;
    logic [SAMPLE_W-1:0] sample;
    logic [CHAN_W-1:0]   converted_channel;
  } acs_in_t;

  typedef struct packed {
    logic                accepted;
    logic [SAMPLE_W-1:0] read_value;
    logic                scan_done;
    logic [CHAN_W-1:0]   select_channel;
    logic                start_conversion;
    logic [STATUS_W-1:0] status;
  } acs_out_t;

  // Classified transaction handed from front to back
  typedef struct packed {
    logic                accepted;
    logic                scan_done;
    logic [CHAN_W-1:0]   select_channel;
    logic                start_conversion;
    logic [STATUS_W-1:0] status;
    logic                vt_we;
    logic                vt_rd;
    logic [IDX_W-1:0]    vt_addr;
    logic [SAMPLE_W-1:0] vt_data;
  } acs_rec_t;

endpackage

// ===== hw/rtl/acs_ram.sv =====
module acs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one entry, register the read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/acs_front.sv =====
module acs_front import acs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  acs_in_t          in_data_i,
  input  logic             cfg_we_i,
  input  logic [LEN_W-1:0] cfg_wdata_i,
  input  logic             q_full_i,
  output logic             push_o,
  output acs_rec_t         rec_o
);

  logic                   enabled_q, enabled_d;
  logic                   idle_q, idle_d;
  logic [POS_W-1:0]       pos_q, pos_d;
  logic [CHAN_W-1:0]      mux_q, mux_d;
  logic [CHAN_W-1:0]      first_q, first_d;
  logic [MAX_ENTRIES-1:0] chan_vld_q, chan_vld_d;
  logic [LEN_W-1:0]       list_len_q;
  logic                   nxt_vld_q;

  logic [LEN_W-1:0]    len;
  logic [POS_W-1:0]    pos_inc;
  logic [IDX_W-1:0]    ct_raddr;
  logic [CHAN_W-1:0]   ct_rdata;
  logic [CHAN_W-1:0]   nxt_chan;
  logic                ct_we;
  logic                accepted;
  logic                start;
  status_e             status;
  logic                vt_we;
  logic                vt_rd;
  logic [IDX_W-1:0]    vt_addr;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // Clamp the list length to the table size
  assign len = (list_len_q > LEN_W'(MAX_ENTRIES)) ? LEN_W'(MAX_ENTRIES) : list_len_q;

  // Entry after the current scan position, prefetched from the channel RAM
  assign pos_inc  = pos_d + POS_W'(1);
  assign ct_raddr = pos_inc[IDX_W-1:0];
  assign nxt_chan = nxt_vld_q ? ct_rdata : '0;

  acs_ram #(
    .WIDTH (CHAN_W),
    .DEPTH (MAX_ENTRIES)
  ) u_chan_ram (
    .clk_i   (clk_i),
    .we_i    (ct_we),
    .waddr_i (in_data_i.entry_index),
    .wdata_i (in_data_i.entry_channel),
    .re_i    (1'b1),
    .raddr_i (ct_raddr),
    .rdata_o (ct_rdata)
  );

  // Decode the request and update the scan state
  always_comb begin
    enabled_d  = enabled_q;
    idle_d     = idle_q;
    pos_d      = pos_q;
    mux_d      = mux_q;
    first_d    = first_q;
    chan_vld_d = chan_vld_q;
    ct_we      = 1'b0;
    accepted   = 1'b0;
    start      = 1'b0;
    status     = ST_OK;
    vt_we      = 1'b0;
    vt_rd      = 1'b0;
    vt_addr    = in_data_i.entry_index;
    if (push_o) begin
      unique case (in_data_i.req_type)
        REQ_INIT: begin
          enabled_d = 1'b1;
          idle_d    = 1'b1;
          pos_d     = '0;
          mux_d     = '0;
          accepted  = 1'b1;
        end
        REQ_WRITE: begin
          if (enabled_q && idle_q) begin
            ct_we = 1'b1;
            chan_vld_d[in_data_i.entry_index] = 1'b1;
            if (in_data_i.entry_index == '0) begin
              first_d = in_data_i.entry_channel;
            end
            accepted = 1'b1;
          end else begin
            status = ST_REJECT;
          end
        end
        REQ_START: begin
          if (enabled_q && idle_q && (len != '0)) begin
            idle_d   = 1'b0;
            pos_d    = '0;
            mux_d    = first_q;
            start    = 1'b1;
            accepted = 1'b1;
          end else begin
            status = ST_REJECT;
          end
        end
        REQ_CONV: begin
          if (idle_q || !enabled_q) begin
            status = ST_REJECT;
          end else if ((len == '0) || (LEN_W'(pos_q) >= len)) begin
            idle_d = 1'b1;
            status = ST_FAULT;
          end else if (in_data_i.converted_channel == mux_q) begin
            // Store the sample, then advance or finish
            vt_we   = 1'b1;
            vt_addr = pos_q[IDX_W-1:0];
            if ((LEN_W + 1)'(pos_q) + (LEN_W + 1)'(1) >= (LEN_W + 1)'(len)) begin
              idle_d = 1'b1;
            end else begin
              pos_d = pos_q + POS_W'(1);
              mux_d = nxt_chan;
              start = 1'b1;
            end
          end else begin
            // Wrong channel converted: restart from the first entry
            pos_d  = '0;
            mux_d  = first_q;
            start  = 1'b1;
            status = ST_MISMATCH;
          end
        end
        REQ_READ: begin
          if (idle_q && (LEN_W'(in_data_i.entry_index) < len)) begin
            vt_rd = 1'b1;
          end else begin
            status = ST_REJECT;
          end
        end
        default: begin
          status = ST_REJECT;
        end
      endcase
    end
  end

  always_comb begin
    rec_o.accepted         = accepted;
    rec_o.scan_done        = idle_d;
    rec_o.select_channel   = mux_d;
    rec_o.start_conversion = start;
    rec_o.status           = status;
    rec_o.vt_we            = vt_we;
    rec_o.vt_rd            = vt_rd;
    rec_o.vt_addr          = vt_addr;
    rec_o.vt_data          = in_data_i.sample;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q  <= 1'b0;
      idle_q     <= 1'b0;
      pos_q      <= '0;
      mux_q      <= '0;
      first_q    <= '0;
      chan_vld_q <= '0;
      list_len_q <= '0;
      nxt_vld_q  <= 1'b0;
    end else begin
      enabled_q  <= enabled_d;
      idle_q     <= idle_d;
      pos_q      <= pos_d;
      mux_q      <= mux_d;
      first_q    <= first_d;
      chan_vld_q <= chan_vld_d;
      nxt_vld_q  <= chan_vld_q[ct_raddr];
      if (cfg_we_i) begin
        list_len_q <= cfg_wdata_i;
      end
    end
  end

endmodule

// ===== hw/rtl/acs_queue.sv =====
module acs_queue import acs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  acs_rec_t push_data_i,
  input  logic     pop_i,
  output acs_rec_t pop_data_o,
  output logic     full_o,
  output logic     empty_o
);

  acs_rec_t          entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  assign full_o     = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = entry_q[rd_ptr_q];

  // Store pushed transactions
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and track the fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/acs_back.sv =====
module acs_back import acs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     q_empty_i,
  input  acs_rec_t rec_i,
  output logic     pop_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output acs_out_t out_data_o
);

  logic [MAX_ENTRIES-1:0] val_vld_q;
  logic                   out_valid_q;
  acs_rec_t               out_rec_q;
  logic                   rd_vld_q;
  logic [SAMPLE_W-1:0]    vt_rdata;

  // Take the next transaction when the output register is free
  assign pop_o = !q_empty_i && (!out_valid_q || !out_stall_i);

  acs_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_ENTRIES)
  ) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (pop_o && rec_i.vt_we),
    .waddr_i (rec_i.vt_addr),
    .wdata_i (rec_i.vt_data),
    .re_i    (pop_o && rec_i.vt_rd),
    .raddr_i (rec_i.vt_addr),
    .rdata_o (vt_rdata)
  );

  // Hold the result payload while the receiver stalls
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_rec_q <= rec_i;
      rd_vld_q  <= val_vld_q[rec_i.vt_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      val_vld_q   <= '0;
    end else begin
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (pop_o && rec_i.vt_we) begin
        val_vld_q[rec_i.vt_addr] <= 1'b1;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    out_data_o.accepted         = out_rec_q.accepted;
    out_data_o.read_value       = (out_rec_q.vt_rd && rd_vld_q) ? vt_rdata : '0;
    out_data_o.scan_done        = out_rec_q.scan_done;
    out_data_o.select_channel   = out_rec_q.select_channel;
    out_data_o.start_conversion = out_rec_q.start_conversion;
    out_data_o.status           = out_rec_q.status;
  end

endmodule

// ===== hw/rtl/adc_channel_scan_sequencer.sv =====
// Scan sequencer for a multichannel ADC with a 32-entry channel list.
// Input channel: in_valid_i / in_stall_o carry one request transaction (init,
// list write, start, conversion complete, value read) per cycle unless stalled.
// Output channel: out_valid_o / out_stall_i carry exactly one result
// transaction per request, in request order.
// Config: cfg_we_i writes list_length from cfg_wdata_i; write only while idle.
// Throughput: one transaction per cycle while in_stall_o is low. The front
// updates the scan state in the accept cycle and prefetches the next list
// entry from the channel RAM. An accepted request is stored in the queue;
// when the output register is free, the back pops it and loads the output
// register and the registered value RAM read at the same edge.
// When the receiver stalls, the result holds, the queue fills, and after two
// more transactions in_stall_o rises until the receiver takes a result.
// Reset: the block is disabled and not done, list_length is 0, and every
// channel and sample entry reads as 0 until written. No clearing pass.
module adc_channel_scan_sequencer import acs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  acs_in_t          in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output acs_out_t         out_data_o,
  input  logic             cfg_we_i,
  input  logic [LEN_W-1:0] cfg_wdata_i
);

  logic     push;
  logic     pop;
  logic     q_full;
  logic     q_empty;
  acs_rec_t push_rec;
  acs_rec_t pop_rec;

  // Accept and classify requests
  acs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .rec_o       (push_rec)
  );

  // Decouple the two sides
  acs_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_rec),
    .pop_i       (pop),
    .pop_data_o  (pop_rec),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  // Access the sample table and deliver results
  acs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .rec_i       (pop_rec),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== sim/adc_channel_scan_sequencer_checker.sv =====
module adc_channel_scan_sequencer_checker import acs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  acs_in_t          in_data_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  acs_out_t         out_data_i,
  input  logic             cfg_we_i,
  input  logic [LEN_W-1:0] cfg_wdata_i,
  output int unsigned      pending_o,
  output int unsigned      errors_o,
  output int unsigned      checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow of the sequencer state
  logic                enabled_q;
  logic                done_q;
  logic [POS_W-1:0]    scan_pos_q;
  logic [CHAN_W-1:0]   mux_q;
  logic [LEN_W-1:0]    list_len_q;
  logic [CHAN_W-1:0]   chan_list_q [MAX_ENTRIES];
  logic [SAMPLE_W-1:0] samples_q [MAX_ENTRIES];

  // Results predicted but not yet seen on the output channel
  acs_out_t expected_results_q[$];

  // Clamp the programmed length to the table size
  function automatic logic [POS_W-1:0] active_length();
    if (list_len_q > MAX_ENTRIES) begin
      return POS_W'(MAX_ENTRIES);
    end
    return list_len_q;
  endfunction

  // Apply one request transaction to the shadow state and form its result
  task automatic scan_step(input acs_in_t req, output acs_out_t res);
    logic [POS_W-1:0] len;
    len = active_length();
    res = '0;
    res.status = ST_OK;
    case (req.req_type)
      REQ_INIT: begin
        enabled_q = 1'b1;
        done_q = 1'b1;
        scan_pos_q = '0;
        mux_q = '0;
        res.accepted = 1'b1;
      end
      REQ_WRITE: begin
        // entry_index cannot exceed the table with a 5-bit field
        if (enabled_q && done_q) begin
          chan_list_q[req.entry_index] = req.entry_channel;
          res.accepted = 1'b1;
        end else begin
          res.status = ST_REJECT;
        end
      end
      REQ_START: begin
        if (enabled_q && done_q && len != 0) begin
          done_q = 1'b0;
          scan_pos_q = '0;
          mux_q = chan_list_q[0];
          res.start_conversion = 1'b1;
          res.accepted = 1'b1;
        end else begin
          res.status = ST_REJECT;
        end
      end
      REQ_CONV: begin
        if (done_q || !enabled_q) begin
          res.status = ST_REJECT;
        end else if (len == 0 || scan_pos_q >= len) begin
          // list shrank under a running scan
          done_q = 1'b1;
          res.status = ST_FAULT;
        end else if (req.converted_channel == chan_list_q[scan_pos_q[IDX_W-1:0]]) begin
          samples_q[scan_pos_q[IDX_W-1:0]] = req.sample;
          if (scan_pos_q + 1 >= len) begin
            done_q = 1'b1;
          end else begin
            scan_pos_q = scan_pos_q + 1'b1;
            mux_q = chan_list_q[scan_pos_q[IDX_W-1:0]];
            res.start_conversion = 1'b1;
          end
        end else begin
          // wrong channel came back: restart from the first entry
          scan_pos_q = '0;
          mux_q = chan_list_q[0];
          res.start_conversion = 1'b1;
          res.status = ST_MISMATCH;
        end
      end
      REQ_READ: begin
        if (done_q && req.entry_index < len) begin
          res.read_value = samples_q[req.entry_index];
        end else begin
          res.status = ST_REJECT;
        end
      end
      default: begin
        res.status = ST_REJECT;
      end
    endcase
    res.scan_done = done_q;
    res.select_channel = mux_q;
  endtask

  function automatic void match_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      errors_o++;
    end
  endfunction

  task automatic compare_result(input acs_out_t want, input acs_out_t got);
    match_field("accepted", want.accepted, got.accepted);
    match_field("read_value", want.read_value, got.read_value);
    match_field("scan_done", want.scan_done, got.scan_done);
    match_field("select_channel", want.select_channel, got.select_channel);
    match_field("start_conversion", want.start_conversion, got.start_conversion);
    match_field("status", want.status, got.status);
    checked_o++;
  endtask

  // Track config writes, predict on accepted requests, check accepted results
  always @(posedge clk_i or negedge rst_ni) begin : watch
    acs_out_t want;
    if (!rst_ni) begin
      enabled_q = 1'b0;
      done_q = 1'b0;
      scan_pos_q = '0;
      mux_q = '0;
      list_len_q = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        chan_list_q[i] = '0;
        samples_q[i] = '0;
      end
      expected_results_q.delete();
      errors_o = 0;
      checked_o = 0;
    end else begin
      if (cfg_we_i) begin
        list_len_q = cfg_wdata_i;
      end
      if (in_valid_i && !in_stall_i) begin
        scan_step(in_data_i, want);
        expected_results_q.push_back(want);
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_results_q.size() == 0) begin
          $error("result transaction with no request outstanding: %h", out_data_i);
          errors_o++;
        end else begin
          want = expected_results_q.pop_front();
          compare_result(want, out_data_i);
        end
      end
    end
    pending_o = expected_results_q.size();
  end

endmodule

// ===== sim/adc_channel_scan_sequencer_test.sv =====
module adc_channel_scan_sequencer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import acs_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned TARGET_REQUESTS = 950;
  localparam int unsigned LONG_HOLD       = 64;
  localparam int unsigned SETTLE_CYCLES   = 4;

  // Request codes the block does not define
  localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd5;
  localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  acs_in_t          in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  acs_out_t         out_data;
  logic             cfg_we = 1'b0;
  logic [LEN_W-1:0] cfg_wdata = '0;

  int unsigned pending;
  int unsigned errors;
  int unsigned checked;
  int unsigned cycles = 0;
  int unsigned requests = 0;
  int unsigned settings = 0;

  // Sequence generator view of the scan, used to aim completions
  bit                enabled = 1'b0;
  bit                running = 1'b0;
  int unsigned       cursor = 0;
  int unsigned       len_now = 0;
  logic [CHAN_W-1:0] list_chan [MAX_ENTRIES] = '{default: '0};

  bit steady = 1'b0;
  bit hold_req = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  adc_channel_scan_sequencer dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  adc_channel_scan_sequencer_checker scan_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .pending_o   (pending),
    .errors_o    (errors),
    .checked_o   (checked)
  );

  // Mostly short idle spans, a few long ones
  function automatic int unsigned random_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 24);
  endfunction

  function automatic acs_in_t random_request(input logic [REQ_W-1:0] kind);
    logic [31:0] bits;
    acs_in_t r;
    bits = $urandom;
    r = bits[$bits(acs_in_t)-1:0];
    r.req_type = kind;
    return r;
  endfunction

  function automatic acs_in_t compose_request(input logic [REQ_W-1:0] kind,
                                              input int unsigned idx, input int unsigned chan,
                                              input int unsigned smp, input int unsigned conv);
    acs_in_t r;
    r.req_type = kind;
    r.entry_index = IDX_W'(idx);
    r.entry_channel = CHAN_W'(chan);
    r.sample = SAMPLE_W'(smp);
    r.converted_channel = CHAN_W'(conv);
    return r;
  endfunction

  // Keep the generator's view of the scan in step with what was sent
  function automatic void follow_scan(input acs_in_t req);
    case (req.req_type)
      REQ_INIT: begin
        enabled = 1'b1;
        running = 1'b0;
        cursor = 0;
      end
      REQ_WRITE: begin
        if (enabled && !running) begin
          list_chan[req.entry_index] = req.entry_channel;
        end
      end
      REQ_START: begin
        if (enabled && !running && len_now != 0) begin
          running = 1'b1;
          cursor = 0;
        end
      end
      REQ_CONV: begin
        if (running) begin
          if (cursor >= len_now) begin
            running = 1'b0;
          end else if (req.converted_channel == list_chan[cursor]) begin
            cursor++;
            if (cursor >= len_now) begin
              running = 1'b0;
            end
          end else begin
            cursor = 0;
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Offer one request transaction and hold it until it is taken
  task automatic push_request(input acs_in_t req);
    int unsigned gap;
    gap = steady ? 0 : random_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall);
    if (req.req_type <= REQ_READ) begin
      requests++;
    end
    follow_scan(req);
  endtask

  // Drop valid and wait for every outstanding result to come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_list_length(input logic [LEN_W-1:0] value);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    len_now = (value > MAX_ENTRIES) ? MAX_ENTRIES : value;
    settings++;
  endtask

  // Mostly short lists, sometimes empty, full or beyond the table
  function automatic logic [LEN_W-1:0] pick_length();
    int unsigned r;
    r = $urandom_range(0, 19);
    case (r)
      0:       return '0;
      1:       return LEN_W'(MAX_ENTRIES);
      2:       return LEN_W'($urandom_range(MAX_ENTRIES + 1, (1 << LEN_W) - 1));
      3, 4:    return LEN_W'($urandom_range(9, MAX_ENTRIES - 1));
      default: return LEN_W'($urandom_range(1, 8));
    endcase
  endfunction

  // Next request: mostly a well-formed scan, some noise and broken sequences
  function automatic acs_in_t next_scan_request();
    int unsigned r;
    acs_in_t q;
    r = $urandom_range(0, 99);
    if (running && r < 80) begin
      q = random_request(REQ_CONV);
      q.converted_channel = list_chan[cursor];
    end else if (running && r < 88) begin
      q = random_request(REQ_CONV);
    end else if (running && r < 91) begin
      q = random_request(REQ_INIT);
    end else if (!running && r < 45) begin
      q = random_request(REQ_START);
    end else if (!running && r < 60) begin
      q = random_request(REQ_WRITE);
    end else if (r < 85) begin
      q = random_request(REQ_READ);
      if (len_now != 0 && $urandom_range(0, 3) != 0) begin
        q.entry_index = IDX_W'($urandom_range(0, len_now - 1));
      end
    end else if (r < 90) begin
      q = random_request(REQ_CONV);
    end else if (r < 93) begin
      q = random_request(REQ_INIT);
    end else if (r < 96) begin
      q = random_request($urandom_range(0, 1) ? REQ_WRITE : REQ_START);
    end else begin
      q = random_request(REQ_W'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI)));
    end
    return q;
  endfunction

  // Output side: random stalls, steady stretches, and one long hold-off
  initial begin : receiver
    int unsigned span;
    bit stall_now;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        stall_now = 1'b1;
        span = LONG_HOLD;
      end else if (steady) begin
        stall_now = 1'b0;
        span = 1;
      end else begin
        stall_now = $urandom_range(0, 1);
        span = random_gap();
        if (!stall_now) begin
          span++;
        end else if (span == 0) begin
          stall_now = 1'b0;
          span = 1;
        end
      end
      out_stall <= stall_now;
      repeat (span) @(posedge clk);
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding", cycles, pending);
      $display("[adc_channel_scan_sequencer] ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned phase;
    phase = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Everything but init is refused before the block is enabled
    push_request(compose_request(REQ_READ, 0, 0, 0, 0));
    push_request(compose_request(REQ_WRITE, 31, 31, 255, 31));
    push_request(random_request(REQ_START));
    push_request(random_request(REQ_CONV));
    push_request(random_request(REQ_SPARE_HI));
    push_request(random_request(REQ_INIT));
    // Empty list refuses start; completion with no scan is stray
    push_request(random_request(REQ_START));
    push_request(random_request(REQ_CONV));

    // Full list: writes and reads refused mid-scan, match then mismatch, abort
    write_list_length(LEN_W'(MAX_ENTRIES));
    push_request(compose_request(REQ_WRITE, 0, 31, 0, 0));
    push_request(compose_request(REQ_WRITE, 31, 0, 255, 31));
    push_request(random_request(REQ_START));
    push_request(compose_request(REQ_WRITE, 5, 5, 0, 0));
    push_request(compose_request(REQ_READ, 0, 0, 0, 0));
    push_request(compose_request(REQ_CONV, 0, 0, 255, 31));
    push_request(compose_request(REQ_CONV, 0, 0, 0, 17));
    push_request(random_request(REQ_INIT));

    // One-entry scan, then a read past range
    write_list_length(1);
    push_request(random_request(REQ_START));
    push_request(compose_request(REQ_CONV, 0, 0, 0, 31));
    push_request(compose_request(REQ_READ, 31, 0, 0, 0));

    // Shrink the list under a running scan, then empty it
    write_list_length(3);
    push_request(random_request(REQ_START));
    push_request(compose_request(REQ_CONV, 0, 0, 128, 31));
    write_list_length(1);
    push_request(compose_request(REQ_CONV, 0, 0, 1, 0));
    push_request(random_request(REQ_START));
    write_list_length(0);
    push_request(compose_request(REQ_CONV, 0, 0, 2, 31));

    // Length beyond the table acts as a full list
    write_list_length('1);
    push_request(compose_request(REQ_READ, 31, 0, 0, 0));
    push_request(random_request(REQ_SPARE_LO));

    // Random phases, each under a fresh list length
    while (requests < TARGET_REQUESTS) begin
      phase++;
      steady = (phase % 6 == 3) || (phase == 4);
      write_list_length(pick_length());
      if (phase == 4) begin
        hold_req = 1'b1;
      end
      if (!running) begin
        for (int i = 0; i < len_now; i++) begin
          if ($urandom_range(0, 1) != 0) begin
            push_request(compose_request(REQ_WRITE, i, $urandom_range(0, 31), 0, 0));
          end
        end
      end
      repeat ($urandom_range(20, 60)) push_request(next_scan_request());
    end

    wait_idle();
    $display("Checked %0d results from %0d requests over %0d list-length settings",
             checked, requests, settings);
    $display("Random phases: %0d, including a %0d-cycle output hold-off", phase, LONG_HOLD);
    if (errors == 0) begin
      $display("[adc_channel_scan_sequencer] OK");
    end else begin
      $display("[adc_channel_scan_sequencer] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/acs_pkg.sv
hw/rtl/acs_ram.sv
hw/rtl/acs_front.sv
hw/rtl/acs_queue.sv
hw/rtl/acs_back.sv
hw/rtl/adc_channel_scan_sequencer.sv
sim/adc_channel_scan_sequencer_checker.sv
sim/adc_channel_scan_sequencer_test.sv
